### rtl/core/lav_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register indexes and payload types for the look-at view matrix block.
// Depends on nothing; every other file in rtl/core imports it.
package lav_pkg;

    // Fixed-point format and derived widths
    localparam int FRAC_BITS = 16;
    localparam int CW        = FRAC_BITS + 2;   // unit vector component, signed
    localparam int TW        = CW + 1;          // true-up component, signed
    localparam int PW        = 32 + CW;         // up x forward product
    localparam int NW        = PW + 1;          // cross product difference
    localparam int LW        = $clog2(NW);      // leading-one position
    localparam int MSB_POS   = 30;              // largest scaled magnitude sits in [2^30, 2^31)
    localparam int MW        = MSB_POS + 1;
    localparam int SW        = 2 * MW + 2;      // sum of squares
    localparam int RW        = SW / 2;          // square root
    localparam int REM_W     = RW + 4;
    localparam int QW        = FRAC_BITS + 1;   // quotient bits
    localparam int NUM_W     = MW + FRAC_BITS + 1;
    localparam int DV_W      = RW + QW;
    localparam int TPW       = 2 * CW;          // forward x right product
    localparam int TDW       = TPW + 1;
    localparam int TMW       = TDW - FRAC_BITS;
    localparam int DPW       = TW + 32;         // basis x position product
    localparam int DW        = DPW + 2;
    localparam int DMW       = DW - FRAC_BITS;

    localparam logic [31:0] FIX_ONE = 32'(1) << FRAC_BITS;

    // Configuration register indexes
    localparam logic [1:0] REG_UP_X = 2'd0;
    localparam logic [1:0] REG_UP_Y = 2'd1;
    localparam logic [1:0] REG_UP_Z = 2'd2;

    // Row codes
    localparam logic [1:0] ROW_RIGHT = 2'd0;
    localparam logic [1:0] ROW_UP    = 2'd1;
    localparam logic [1:0] ROW_FWD   = 2'd2;

    // Item context carried through a normalizer
    typedef struct packed {
        logic                  deg;
        logic [2:0][CW-1:0]    fwd;
        logic [2:0][31:0]      pos;
    } lav_pay_t;

endpackage

### rtl/core/lav_norm.sv
`timescale 1ns / 1ps
// Pipelined 3-vector normalizer: scale, sum of squares, square root, per-lane divide.
// Depends on lav_pkg. Accepts one item per cycle.
module lav_norm (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_vld,
    input  logic [2:0][lav_pkg::NW-1:0]   in_vec,
    input  lav_pkg::lav_pay_t             in_pay,
    output logic                          out_vld,
    output logic [2:0][lav_pkg::CW-1:0]   out_vec,
    output logic                          out_zero,
    output lav_pkg::lav_pay_t             out_pay
);
    import lav_pkg::*;

    typedef struct packed {
        logic [2:0]           neg;
        logic                 zero;
        logic [2:0][MW-1:0]   m;
        lav_pay_t             pay;
    } nctx_t;

    // Magnitude stage
    logic               n0_vld_reg;
    logic [2:0]         n0_neg_reg;
    logic [2:0][NW-1:0] n0_mag_reg;
    lav_pay_t           n0_pay_reg;
    logic [2:0]         n0_neg_next;
    logic [2:0][NW-1:0] n0_mag_next;

    // Shift search stage
    logic               n1_vld_reg;
    logic [2:0]         n1_neg_reg;
    logic [2:0][NW-1:0] n1_mag_reg;
    lav_pay_t           n1_pay_reg;
    logic               n1_zero_reg;
    logic               n1_right_reg;
    logic [LW-1:0]      n1_amt_reg;
    logic [NW-1:0]      n1_or;
    logic [LW-1:0]      n1_lead;
    logic               n1_right_next;
    logic [LW-1:0]      n1_amt_next;

    // Scaled magnitudes
    logic               n2_vld_reg;
    nctx_t              n2_ctx_reg;
    logic [2:0][NW-1:0] n2_sh;

    // Squares
    logic                 n3_vld_reg;
    nctx_t                n3_ctx_reg;
    logic [2:0][2*MW-1:0] n3_sq_reg;

    // Square root stages, index 0 holds the sum of squares
    logic [RW:0]        sq_vld_reg;
    nctx_t              sq_ctx_reg  [RW+1];
    logic [SW-1:0]      sq_rad_reg  [RW+1];
    logic [REM_W-1:0]   sq_rem_reg  [RW+1];
    logic [RW-1:0]      sq_root_reg [RW+1];

    // Divider stages, one quotient bit per stage
    logic [QW:0]          dv_vld_reg;
    nctx_t                dv_ctx_reg [QW+1];
    logic [RW-1:0]        dv_len_reg [QW+1];
    logic [2:0][NUM_W-1:0] dv_rem_reg [QW+1];
    logic [2:0][QW-1:0]   dv_q_reg   [QW+1];
    logic [2:0][NUM_W-1:0] dv_num_next;

    // Output stage
    logic               o_vld_reg;
    logic [2:0][CW-1:0] o_vec_reg;
    logic               o_zero_reg;
    lav_pay_t           o_pay_reg;

    // Take magnitudes
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n0_neg_next[i] = in_vec[i][NW-1];
            n0_mag_next[i] = n0_neg_next[i] ? (~in_vec[i] + NW'(1)) : in_vec[i];
        end
    end

    // Find the leading one of all three magnitudes and the shift that puts it at MSB_POS
    always_comb
    begin
        n1_or   = n0_mag_reg[0] | n0_mag_reg[1] | n0_mag_reg[2];
        n1_lead = '0;
        for (int k = 0; k < NW; k++)
        begin
            if (n1_or[k])
            begin
                n1_lead = LW'(k);
            end
        end
        n1_right_next = n1_lead > LW'(MSB_POS);
        n1_amt_next   = n1_right_next ? (n1_lead - LW'(MSB_POS)) : (LW'(MSB_POS) - n1_lead);
    end

    // Apply the common shift, truncating on right shifts
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n2_sh[i] = n1_right_reg ? (n1_mag_reg[i] >> n1_amt_reg)
                                    : (n1_mag_reg[i] << n1_amt_reg);
        end
    end

    // Build dividends: (m << FRAC_BITS) + len / 2
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dv_num_next[i] = (NUM_W'(sq_ctx_reg[RW].m[i]) << FRAC_BITS)
                           + NUM_W'(sq_root_reg[RW] >> 1);
        end
    end

    // Valid bits of the front stages, the square root and divider entries and the output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n0_vld_reg    <= 1'b0;
            n1_vld_reg    <= 1'b0;
            n2_vld_reg    <= 1'b0;
            n3_vld_reg    <= 1'b0;
            sq_vld_reg[0] <= 1'b0;
            dv_vld_reg[0] <= 1'b0;
            o_vld_reg     <= 1'b0;
        end
        else
        begin
            n0_vld_reg    <= in_vld;
            n1_vld_reg    <= n0_vld_reg;
            n2_vld_reg    <= n1_vld_reg;
            n3_vld_reg    <= n2_vld_reg;
            sq_vld_reg[0] <= n3_vld_reg;
            dv_vld_reg[0] <= sq_vld_reg[RW];
            o_vld_reg     <= dv_vld_reg[QW];
        end
    end

    // Front stage payload and the square root and divider entries
    always_ff @(posedge clk)
    begin
        n0_neg_reg <= n0_neg_next;
        n0_mag_reg <= n0_mag_next;
        n0_pay_reg <= in_pay;

        n1_neg_reg   <= n0_neg_reg;
        n1_mag_reg   <= n0_mag_reg;
        n1_pay_reg   <= n0_pay_reg;
        n1_zero_reg  <= (n1_or == '0);
        n1_right_reg <= n1_right_next;
        n1_amt_reg   <= n1_amt_next;

        n2_ctx_reg.neg  <= n1_neg_reg;
        n2_ctx_reg.zero <= n1_zero_reg;
        n2_ctx_reg.pay  <= n1_pay_reg;
        for (int i = 0; i < 3; i++)
        begin
            n2_ctx_reg.m[i] <= n2_sh[i][MW-1:0];
        end

        n3_ctx_reg <= n2_ctx_reg;
        for (int i = 0; i < 3; i++)
        begin
            n3_sq_reg[i] <= n2_ctx_reg.m[i] * n2_ctx_reg.m[i];
        end

        sq_ctx_reg[0]  <= n3_ctx_reg;
        sq_rad_reg[0]  <= SW'(n3_sq_reg[0]) + SW'(n3_sq_reg[1]) + SW'(n3_sq_reg[2]);
        sq_rem_reg[0]  <= '0;
        sq_root_reg[0] <= '0;

        dv_ctx_reg[0] <= sq_ctx_reg[RW];
        dv_len_reg[0] <= sq_root_reg[RW];
        dv_rem_reg[0] <= dv_num_next;
        dv_q_reg[0]   <= '0;
    end

    // Square root: one result bit per stage
    for (genvar k = 0; k < RW; k++)
    begin : g_sqrt
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic             fit;

        always_comb
        begin
            rem_sh = {sq_rem_reg[k][REM_W-3:0], sq_rad_reg[k][SW-1 -: 2]};
            trial  = REM_W'({sq_root_reg[k], 2'b01});
            fit    = rem_sh >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                sq_vld_reg[k+1] <= sq_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_ctx_reg[k+1]  <= sq_ctx_reg[k];
            sq_rad_reg[k+1]  <= sq_rad_reg[k] << 2;
            sq_rem_reg[k+1]  <= fit ? (rem_sh - trial) : rem_sh;
            sq_root_reg[k+1] <= {sq_root_reg[k][RW-2:0], fit};
        end
    end

    // Restoring divide: one quotient bit per stage, three lanes
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        localparam int B = QW - 1 - k;
        logic [DV_W-1:0] dvs;
        logic [2:0]      fit;

        always_comb
        begin
            dvs = DV_W'(dv_len_reg[k]) << B;
            for (int i = 0; i < 3; i++)
            begin
                fit[i] = DV_W'(dv_rem_reg[k][i]) >= dvs;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_ctx_reg[k+1] <= dv_ctx_reg[k];
            dv_len_reg[k+1] <= dv_len_reg[k];
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[k+1][i] <= fit[i] ? (dv_rem_reg[k][i] - dvs[NUM_W-1:0])
                                             : dv_rem_reg[k][i];
                dv_q_reg[k+1][i]   <= {dv_q_reg[k][i][QW-2:0], fit[i]};
            end
        end
    end

    // Restore signs, force zero vectors to zero
    always_ff @(posedge clk)
    begin
        o_zero_reg <= dv_ctx_reg[QW].zero;
        o_pay_reg  <= dv_ctx_reg[QW].pay;
        for (int i = 0; i < 3; i++)
        begin
            if (dv_ctx_reg[QW].zero)
            begin
                o_vec_reg[i] <= '0;
            end
            else if (dv_ctx_reg[QW].neg[i])
            begin
                o_vec_reg[i] <= CW'(0) - CW'(dv_q_reg[QW][i]);
            end
            else
            begin
                o_vec_reg[i] <= CW'(dv_q_reg[QW][i]);
            end
        end
    end

    assign out_vld  = o_vld_reg;
    assign out_vec  = o_vec_reg;
    assign out_zero = o_zero_reg;
    assign out_pay  = o_pay_reg;

endmodule

### rtl/core/look_at_view_matrix.sv
`timescale 1ns / 1ps
// Top level of the look-at view matrix block: config registers, cross products, rows, output.
// Depends on lav_pkg and lav_norm.
//
//  channel   | handshake            | fields
//  ----------+----------------------+------------------------------------------------------
//  command   | start / busy         | camera_x/y/z, target_x/y/z
//  config    | wr_en                | wr_index, wr_data
//  result    | result_valid strobe  | row_index, col_x/y/z, translation, last_row, degenerate
//
// An item is taken when start is high and busy is low; busy is then held high by the cd_reg
// spacing counter, so that the three result rows of one item do not overlap the next item's.
// Rows 0, 1, 2 appear on consecutive cycles; between intake and the first row lie two chained
// normalizers, the cross product and true-up stages and the translation pipe.
// Reset clears all valid bits and loads the up vector with (0, 1.0, 0). No clearing pass.
// The receiver cannot stall; every result is shown for exactly one cycle.
module look_at_view_matrix (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] camera_x,
    input  logic signed [31:0] camera_y,
    input  logic signed [31:0] camera_z,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [31:0]        wr_data,
    output logic               result_valid,
    output logic [1:0]         row_index,
    output logic signed [31:0] col_x,
    output logic signed [31:0] col_y,
    output logic signed [31:0] col_z,
    output logic signed [31:0] translation,
    output logic               last_row,
    output logic               degenerate
);
    import lav_pkg::*;

    typedef struct packed {
        logic                 deg;
        logic [2:0][CW-1:0]   fwd;
        logic [2:0][CW-1:0]   rt;
        logic [2:0][31:0]     pos;
    } yctx_t;

    // Config and intake
    logic [31:0]         up_x_reg, up_y_reg, up_z_reg;
    logic [1:0]          cd_reg;
    logic                accept;
    logic                in_vld_reg;
    logic [2:0][31:0]    in_pos_reg;
    logic [2:0][32:0]    in_dif_reg;
    logic [2:0][NW-1:0]  nf_vec;
    lav_pay_t            nf_pay;

    // Forward normalizer
    logic                f_vld;
    logic [2:0][CW-1:0]  f_vec;
    logic                f_zero;
    lav_pay_t            f_pay;

    // Up x forward
    logic                x1_vld_reg;
    logic [5:0][PW-1:0]  x1_prod_reg;
    lav_pay_t            x1_pay_reg;
    logic                x2_vld_reg;
    logic [2:0][NW-1:0]  x2_vec_reg;
    lav_pay_t            x2_pay_reg;

    // Right normalizer
    logic                r_vld;
    logic [2:0][CW-1:0]  r_vec;
    logic                r_zero;
    lav_pay_t            r_pay;

    // True up = forward x right
    logic                y1_vld_reg, y2_vld_reg, y3_vld_reg, y4_vld_reg;
    yctx_t               y1_ctx_reg, y2_ctx_reg, y3_ctx_reg, y4_ctx_reg;
    logic [5:0][TPW-1:0] y1_prod_reg;
    logic [2:0][TDW-1:0] y2_dif_reg;
    logic [2:0]          y3_neg_reg;
    logic [2:0][TMW-1:0] y3_mag_reg;
    logic [2:0][TW-1:0]  y4_tu_reg;
    logic [2:0][TDW-1:0] y3_abs;

    // Row sequencer
    logic                seq_active_reg;
    logic [1:0]          seq_cnt_reg;
    yctx_t               seq_ctx_reg;
    logic [2:0][TW-1:0]  seq_tu_reg;
    logic [2:0][TW-1:0]  row_b;

    // Translation pipe
    logic                d1_vld_reg, d2_vld_reg, d3_vld_reg;
    logic [1:0]          d1_row_reg, d2_row_reg, d3_row_reg;
    logic                d1_deg_reg, d2_deg_reg, d3_deg_reg;
    logic [2:0][TW-1:0]  d1_b_reg, d2_b_reg, d3_b_reg;
    logic [2:0][DPW-1:0] d1_prod_reg;
    logic [DW-1:0]       d2_sum_reg;
    logic                d3_neg_reg;
    logic [DMW-1:0]      d3_mag_reg;
    logic [DW-1:0]       d3_abs;
    logic [31:0]         d4_trans;

    // Output registers
    logic                res_vld_reg;
    logic [1:0]          res_row_reg;
    logic [2:0][31:0]    res_col_reg;
    logic [31:0]         res_trans_reg;
    logic                res_last_reg;
    logic                res_deg_reg;

    assign accept = start && !busy;
    assign busy   = (cd_reg != 2'd0);

    // Hold config registers and the intake spacing counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_x_reg   <= '0;
            up_y_reg   <= FIX_ONE;
            up_z_reg   <= '0;
            cd_reg     <= 2'd0;
            in_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_UP_X: up_x_reg <= wr_data;
                    REG_UP_Y: up_y_reg <= wr_data;
                    REG_UP_Z: up_z_reg <= wr_data;
                    default:  ;
                endcase
            end
            if (accept)
            begin
                cd_reg <= 2'd2;
            end
            else if (cd_reg != 2'd0)
            begin
                cd_reg <= cd_reg - 2'd1;
            end
            in_vld_reg <= accept;
        end
    end

    // Capture position and camera-minus-target
    always_ff @(posedge clk)
    begin
        in_pos_reg[0] <= camera_x;
        in_pos_reg[1] <= camera_y;
        in_pos_reg[2] <= camera_z;
        in_dif_reg[0] <= 33'(camera_x) - 33'(target_x);
        in_dif_reg[1] <= 33'(camera_y) - 33'(target_y);
        in_dif_reg[2] <= 33'(camera_z) - 33'(target_z);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nf_vec[i] = NW'($signed(in_dif_reg[i]));
        end
        nf_pay.deg = 1'b0;
        nf_pay.fwd = '0;
        nf_pay.pos = in_pos_reg;
    end

    lav_norm u_nrm_fwd (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (in_vld_reg),
        .in_vec   (nf_vec),
        .in_pay   (nf_pay),
        .out_vld  (f_vld),
        .out_vec  (f_vec),
        .out_zero (f_zero),
        .out_pay  (f_pay)
    );

    // Up x forward: products, then differences
    always_ff @(posedge clk)
    begin
        x1_prod_reg[0] <= $signed(up_y_reg) * $signed(f_vec[2]);
        x1_prod_reg[1] <= $signed(up_z_reg) * $signed(f_vec[1]);
        x1_prod_reg[2] <= $signed(up_z_reg) * $signed(f_vec[0]);
        x1_prod_reg[3] <= $signed(up_x_reg) * $signed(f_vec[2]);
        x1_prod_reg[4] <= $signed(up_x_reg) * $signed(f_vec[1]);
        x1_prod_reg[5] <= $signed(up_y_reg) * $signed(f_vec[0]);
        x1_pay_reg.deg <= f_zero;
        x1_pay_reg.fwd <= f_vec;
        x1_pay_reg.pos <= f_pay.pos;

        for (int i = 0; i < 3; i++)
        begin
            x2_vec_reg[i] <= NW'($signed(x1_prod_reg[2*i])) - NW'($signed(x1_prod_reg[2*i+1]));
        end
        x2_pay_reg <= x1_pay_reg;
    end

    lav_norm u_nrm_rt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (x2_vld_reg),
        .in_vec   (x2_vec_reg),
        .in_pay   (x2_pay_reg),
        .out_vld  (r_vld),
        .out_vec  (r_vec),
        .out_zero (r_zero),
        .out_pay  (r_pay)
    );

    // Magnitude of the true-up differences
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            y3_abs[i] = y2_dif_reg[i][TDW-1] ? (~y2_dif_reg[i] + TDW'(1)) : y2_dif_reg[i];
        end
    end

    // True up: products, differences, round half away from zero, sign
    always_ff @(posedge clk)
    begin
        y1_prod_reg[0] <= $signed(r_pay.fwd[1]) * $signed(r_vec[2]);
        y1_prod_reg[1] <= $signed(r_pay.fwd[2]) * $signed(r_vec[1]);
        y1_prod_reg[2] <= $signed(r_pay.fwd[2]) * $signed(r_vec[0]);
        y1_prod_reg[3] <= $signed(r_pay.fwd[0]) * $signed(r_vec[2]);
        y1_prod_reg[4] <= $signed(r_pay.fwd[0]) * $signed(r_vec[1]);
        y1_prod_reg[5] <= $signed(r_pay.fwd[1]) * $signed(r_vec[0]);
        y1_ctx_reg.deg <= r_pay.deg | r_zero;
        y1_ctx_reg.fwd <= r_pay.fwd;
        y1_ctx_reg.rt  <= r_vec;
        y1_ctx_reg.pos <= r_pay.pos;

        for (int i = 0; i < 3; i++)
        begin
            y2_dif_reg[i] <= TDW'($signed(y1_prod_reg[2*i])) - TDW'($signed(y1_prod_reg[2*i+1]));
        end
        y2_ctx_reg <= y1_ctx_reg;

        for (int i = 0; i < 3; i++)
        begin
            y3_neg_reg[i] <= y2_dif_reg[i][TDW-1];
            y3_mag_reg[i] <= TMW'((y3_abs[i] + (TDW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
        end
        y3_ctx_reg <= y2_ctx_reg;

        for (int i = 0; i < 3; i++)
        begin
            y4_tu_reg[i] <= y3_neg_reg[i] ? (TW'(0) - TW'(y3_mag_reg[i])) : TW'(y3_mag_reg[i]);
        end
        y4_ctx_reg <= y3_ctx_reg;
    end

    // Valid bits and the row sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_vld_reg     <= 1'b0;
            x2_vld_reg     <= 1'b0;
            y1_vld_reg     <= 1'b0;
            y2_vld_reg     <= 1'b0;
            y3_vld_reg     <= 1'b0;
            y4_vld_reg     <= 1'b0;
            seq_active_reg <= 1'b0;
            seq_cnt_reg    <= ROW_RIGHT;
            d1_vld_reg     <= 1'b0;
            d2_vld_reg     <= 1'b0;
            d3_vld_reg     <= 1'b0;
            res_vld_reg    <= 1'b0;
        end
        else
        begin
            x1_vld_reg <= f_vld;
            x2_vld_reg <= x1_vld_reg;
            y1_vld_reg <= r_vld;
            y2_vld_reg <= y1_vld_reg;
            y3_vld_reg <= y2_vld_reg;
            y4_vld_reg <= y3_vld_reg;
            if (y4_vld_reg)
            begin
                seq_active_reg <= 1'b1;
                seq_cnt_reg    <= ROW_RIGHT;
            end
            else if (seq_active_reg)
            begin
                if (seq_cnt_reg == ROW_FWD)
                begin
                    seq_active_reg <= 1'b0;
                end
                else
                begin
                    seq_cnt_reg <= seq_cnt_reg + 2'd1;
                end
            end
            d1_vld_reg  <= seq_active_reg;
            d2_vld_reg  <= d1_vld_reg;
            d3_vld_reg  <= d2_vld_reg;
            res_vld_reg <= d3_vld_reg;
        end
    end

    // Load a finished item into the sequencer
    always_ff @(posedge clk)
    begin
        if (y4_vld_reg)
        begin
            seq_ctx_reg <= y4_ctx_reg;
            seq_tu_reg  <= y4_tu_reg;
        end
    end

    // Select the basis vector of the current row
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            case (seq_cnt_reg)
                ROW_RIGHT: row_b[i] = TW'($signed(seq_ctx_reg.rt[i]));
                ROW_UP:    row_b[i] = seq_tu_reg[i];
                ROW_FWD:   row_b[i] = TW'($signed(seq_ctx_reg.fwd[i]));
                default:   row_b[i] = '0;
            endcase
        end
    end

    // Magnitude of the dot product
    assign d3_abs = d2_sum_reg[DW-1] ? (~d2_sum_reg + DW'(1)) : d2_sum_reg;

    // Negate and saturate the rounded dot product
    always_comb
    begin
        if (d3_neg_reg)
        begin
            d4_trans = (d3_mag_reg > DMW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : d3_mag_reg[31:0];
        end
        else
        begin
            d4_trans = (d3_mag_reg > DMW'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
                                                                 : (32'd0 - d3_mag_reg[31:0]);
        end
    end

    // Translation pipe: products, sum, round, saturate
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            d1_prod_reg[i] <= $signed(row_b[i]) * $signed(seq_ctx_reg.pos[i]);
        end
        d1_b_reg   <= row_b;
        d1_row_reg <= seq_cnt_reg;
        d1_deg_reg <= seq_ctx_reg.deg;

        d2_sum_reg <= DW'($signed(d1_prod_reg[0])) + DW'($signed(d1_prod_reg[1]))
                    + DW'($signed(d1_prod_reg[2]));
        d2_b_reg   <= d1_b_reg;
        d2_row_reg <= d1_row_reg;
        d2_deg_reg <= d1_deg_reg;

        d3_neg_reg <= d2_sum_reg[DW-1];
        d3_mag_reg <= DMW'((d3_abs + (DW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
        d3_b_reg   <= d2_b_reg;
        d3_row_reg <= d2_row_reg;
        d3_deg_reg <= d2_deg_reg;

        for (int i = 0; i < 3; i++)
        begin
            res_col_reg[i] <= 32'($signed(d3_b_reg[i]));
        end
        res_trans_reg <= d4_trans;
        res_row_reg   <= d3_row_reg;
        res_last_reg  <= (d3_row_reg == ROW_FWD);
        res_deg_reg   <= d3_deg_reg;
    end

    assign result_valid = res_vld_reg;
    assign row_index    = res_row_reg;
    assign col_x        = res_col_reg[0];
    assign col_y        = res_col_reg[1];
    assign col_z        = res_col_reg[2];
    assign translation  = res_trans_reg;
    assign last_row     = res_last_reg;
    assign degenerate   = res_deg_reg;

endmodule

### rtl/core/lav_chk.sv
`timescale 1ns / 1ps
// Port-level checks for look_at_view_matrix and the bind that attaches them.
// Depends on lav_pkg and the top level's port names.
module lav_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       result_valid,
    input logic [1:0] row_index,
    input logic       last_row,
    input logic       degenerate
);
    import lav_pkg::*;

    // Busy holds off the next item after a take
    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy ##1 busy)
        else $error("busy did not cover the item spacing");

    // Row 0 is followed by row 1
    a_row_up: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && row_index == ROW_RIGHT |=> result_valid && row_index == ROW_UP)
        else $error("row 1 did not follow row 0");

    // Row 1 is followed by row 2
    a_row_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && row_index == ROW_UP |=> result_valid && row_index == ROW_FWD)
        else $error("row 2 did not follow row 1");

    // Last mark only on the forward row
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> last_row == (row_index == ROW_FWD))
        else $error("last_row does not match row 2");

    // Degenerate flag is the same on all rows of an item
    a_deg: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && row_index != ROW_RIGHT |-> $stable(degenerate))
        else $error("degenerate changed within an item");

endmodule

bind look_at_view_matrix lav_chk u_lav_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .row_index    (row_index),
    .last_row     (last_row),
    .degenerate   (degenerate)
);

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for look_at_view_matrix: drives camera/target items, rewrites the up
// vector between phases, and compares every emitted row with an in-bench fixed-point model.
// Depends on lav_pkg and the look_at_view_matrix RTL.
module tb_top;
    import lav_pkg::*;

    localparam int ROW_LATENCY = 2 * FRAC_BITS + 91;

    typedef struct {
        logic [1:0]  row;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [31:0] tr;
        logic        last;
        logic        deg;
    } row_t;

    typedef struct {
        logic [31:0] cam [3];
        logic [31:0] tgt [3];
        bit          collapsed;   // camera on target: rows typed in as zeros
    } view_item_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] camera_x, camera_y, camera_z;
    logic signed [31:0] target_x, target_y, target_z;
    logic               wr_en;
    logic [1:0]         wr_index;
    logic [31:0]        wr_data;
    logic               result_valid;
    logic [1:0]         row_index;
    logic signed [31:0] col_x, col_y, col_z, translation;
    logic               last_row;
    logic               degenerate;

    row_t        pending_rows[$];
    logic [31:0] up_reg [3];
    int          mismatches;
    bit          failed;
    int          burst_left;

    look_at_view_matrix dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .camera_x(camera_x), .camera_y(camera_y), .camera_z(camera_z),
        .target_x(target_x), .target_y(target_y), .target_z(target_z),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .result_valid(result_valid), .row_index(row_index),
        .col_x(col_x), .col_y(col_y), .col_z(col_z), .translation(translation),
        .last_row(last_row), .degenerate(degenerate)
    );

    always #4 clk = ~clk;

    // Magnitude of a signed 64-bit value
    function automatic longint unsigned abs64(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Bring a double-width product back to FRAC_BITS, half away from zero
    function automatic longint round_frac(input longint x);
        longint unsigned m;
        longint unsigned r;
        m = abs64(x);
        r = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return (x < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Unit vector; returns 0 when the input has zero length
    function automatic bit unit_vec(input longint vx, vy, vz,
                                    output longint ox, oy, oz);
        longint unsigned m0, m1, m2, big, len;
        m0 = abs64(vx);
        m1 = abs64(vy);
        m2 = abs64(vz);
        big = m0;
        if (m1 > big) big = m1;
        if (m2 > big) big = m2;
        ox = 0; oy = 0; oz = 0;
        if (big == 0)
            return 0;
        while (big >= (64'd1 << 31))
        begin
            big = big >> 1; m0 = m0 >> 1; m1 = m1 >> 1; m2 = m2 >> 1;
        end
        while (big < (64'd1 << 30))
        begin
            big = big << 1; m0 = m0 << 1; m1 = m1 << 1; m2 = m2 << 1;
        end
        len = int_sqrt(m0 * m0 + m1 * m1 + m2 * m2);
        ox = longint'(((m0 << FRAC_BITS) + (len >> 1)) / len);
        oy = longint'(((m1 << FRAC_BITS) + (len >> 1)) / len);
        oz = longint'(((m2 << FRAC_BITS) + (len >> 1)) / len);
        if (vx < 0) ox = -ox;
        if (vy < 0) oy = -oy;
        if (vz < 0) oz = -oz;
        return 1;
    endfunction

    // Work out the three view rows of one item and queue them
    task automatic predict_rows(input view_item_t it);
        longint p[3], b[3][3];
        longint dx, dy, dz, ux, uy, uz, cx, cy, cz, dot, t;
        bit ok;
        row_t r;
        for (int i = 0; i < 3; i++)
            p[i] = longint'($signed(it.cam[i]));
        dx = p[0] - longint'($signed(it.tgt[0]));
        dy = p[1] - longint'($signed(it.tgt[1]));
        dz = p[2] - longint'($signed(it.tgt[2]));
        ux = longint'($signed(up_reg[0]));
        uy = longint'($signed(up_reg[1]));
        uz = longint'($signed(up_reg[2]));
        ok = unit_vec(dx, dy, dz, b[2][0], b[2][1], b[2][2]);
        cx = uy * b[2][2] - uz * b[2][1];
        cy = uz * b[2][0] - ux * b[2][2];
        cz = ux * b[2][1] - uy * b[2][0];
        ok = unit_vec(cx, cy, cz, b[0][0], b[0][1], b[0][2]) & ok;
        b[1][0] = round_frac(b[2][1] * b[0][2] - b[2][2] * b[0][1]);
        b[1][1] = round_frac(b[2][2] * b[0][0] - b[2][0] * b[0][2]);
        b[1][2] = round_frac(b[2][0] * b[0][1] - b[2][1] * b[0][0]);
        for (int k = 0; k < 3; k++)
        begin
            dot = b[k][0] * p[0] + b[k][1] * p[1] + b[k][2] * p[2];
            t = -round_frac(dot);
            if (t > 64'sd2147483647) t = 64'sd2147483647;
            if (t < -64'sd2147483648) t = -64'sd2147483648;
            r.row  = 2'(k);
            r.cx   = b[k][0][31:0];
            r.cy   = b[k][1][31:0];
            r.cz   = b[k][2][31:0];
            r.tr   = t[31:0];
            r.last = (2'(k) == ROW_FWD);
            r.deg  = !ok;
            if (it.collapsed)
            begin
                // camera on target: every row is zero and flagged
                r.cx = 0; r.cy = 0; r.cz = 0; r.tr = 0; r.deg = 1'b1;
            end
            pending_rows.push_back(r);
        end
    endtask

    // Present one item, hold it until taken, queue its rows
    task automatic send_item(input view_item_t it);
        start    <= 1'b1;
        camera_x <= it.cam[0]; camera_y <= it.cam[1]; camera_z <= it.cam[2];
        target_x <= it.tgt[0]; target_y <= it.tgt[1]; target_z <= it.tgt[2];
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
            @(posedge clk);
        end
        @(posedge clk);
        predict_rows(it);
        // bursts of random length with random gaps
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    // Wait until all rows are in, then rewrite the up vector
    task automatic load_up(input logic [31:0] x, y, z);
        start <= 1'b0;
        wait (pending_rows.size() == 0);
        repeat (8) @(posedge clk);
        wr_en <= 1'b1; wr_index <= REG_UP_X; wr_data <= x;
        @(posedge clk);
        wr_index <= REG_UP_Y; wr_data <= y;
        @(posedge clk);
        wr_index <= REG_UP_Z; wr_data <= z;
        @(posedge clk);
        wr_en <= 1'b0;
        up_reg[0] = x; up_reg[1] = y; up_reg[2] = z;
    endtask

    function automatic view_item_t make_item(input logic [31:0] c0, c1, c2, t0, t1, t2,
                                             input bit collapsed);
        view_item_t it;
        it.cam[0] = c0; it.cam[1] = c1; it.cam[2] = c2;
        it.tgt[0] = t0; it.tgt[1] = t1; it.tgt[2] = t2;
        it.collapsed = collapsed;
        return it;
    endfunction

    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h001FFFFF)) - 32'sh000FFFFF);
            default: return 32'($signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh00FFFFFF);
        endcase
    endfunction

    task automatic run_random(input int count);
        view_item_t it;
        int mode;
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++)
            begin
                it.cam[i] = rand_coord(mode);
                it.tgt[i] = rand_coord(mode);
            end
            it.collapsed = 0;
            case ($urandom_range(0, 9))
                0: it.tgt = it.cam;                     // camera on target
                1: it.tgt[0] = it.cam[0] + $urandom_range(0, 3);
                default: ;
            endcase
            it.collapsed = (it.tgt == it.cam);
            send_item(it);
        end
    endtask

    // Compare every emitted row with the oldest pending row
    always @(negedge clk)
    begin
        row_t e;
        if (rst_n && result_valid)
        begin
            if (pending_rows.size() == 0)
            begin
                failed = 1;
                $display("unexpected row %0d at %0t", row_index, $realtime);
            end
            else
            begin
                e = pending_rows.pop_front();
                if (e.row !== row_index || e.cx !== col_x || e.cy !== col_y
                    || e.cz !== col_z || e.tr !== translation
                    || e.last !== last_row || e.deg !== degenerate)
                begin
                    failed = 1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row mismatch: exp %0d %h %h %h %h %b %b got %0d %h %h %h %h %b %b",
                                 e.row, e.cx, e.cy, e.cz, e.tr, e.last, e.deg,
                                 row_index, col_x, col_y, col_z, translation,
                                 last_row, degenerate);
                end
            end
        end
    end

    // Hard stop
    initial
    begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        view_item_t directed [$];
        clk = 0; rst_n = 0; start = 0; wr_en = 0; wr_index = REG_UP_X; wr_data = 0;
        camera_x = 0; camera_y = 0; camera_z = 0;
        target_x = 0; target_y = 0; target_z = 0;
        mismatches = 0; failed = 0; burst_left = 0;
        up_reg[0] = 0; up_reg[1] = FIX_ONE; up_reg[2] = 0;

        directed = '{
            make_item(0, 0, 0, 0, 0, 0, 1),
            make_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1),
            make_item(32'h80000000, 32'h80000000, 32'h80000000,
                      32'h80000000, 32'h80000000, 32'h80000000, 1),
            make_item(0, 0, FIX_ONE, 0, 0, 0, 0),
            make_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                      32'h80000000, 32'h80000000, 32'h80000000, 0),
            make_item(32'h80000000, 32'h80000000, 32'h80000000,
                      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0),
            make_item(0, FIX_ONE, 0, 0, 0, 0, 0),
            make_item(0, 32'h80000000, 0, 0, 32'h7FFFFFFF, 0, 0),
            make_item(1, 0, 0, 0, 0, 0, 0),
            make_item(32'h7FFFFFFF, 0, 0, 32'h80000000, 0, 0, 0),
            make_item(0, 0, 32'h7FFFFFFF, 0, 0, 0, 0),
            make_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                      32'h7FFFFFFE, 32'h7FFFFFFE, 32'h7FFFFFFE, 0),
            make_item(32'h80000000, 32'h80000000, 32'h80000000,
                      32'h80000001, 32'h80000001, 32'h80000001, 0),
            make_item(32'hFFFF0000, 32'h00030000, 32'hFFFB8000, 32'h00010000, 0, 0, 0)
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_item(directed[i]);
        run_random(25);

        load_up(32'h7FFFFFFF, 32'h80000000, 0);
        foreach (directed[i])
            send_item(directed[i]);
        run_random(17);

        // zero up vector: right row always collapses
        load_up(0, 0, 0);
        run_random(25);

        load_up(32'h80000000, 32'h80000000, 32'h80000000);
        run_random(35);

        load_up($urandom, $urandom, $urandom);
        run_random(35);

        load_up(0, 0, FIX_ONE);
        run_random(35);

        load_up(0, FIX_ONE, 0);
        run_random(20);

        start <= 1'b0;
        wait (pending_rows.size() == 0);
        repeat (ROW_LATENCY + 10) @(posedge clk);
        if (pending_rows.size() != 0)
            failed = 1;
        if (!failed)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

### look_at_view_matrix.f
rtl/core/lav_pkg.sv
rtl/core/lav_norm.sv
rtl/core/look_at_view_matrix.sv
rtl/core/lav_chk.sv
bench/tb_top.sv
